>>> hw/rtl/tbd_pkg.sv
// shared types, constants and palette helpers for the texture block decoder
package tbd_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned ModeW = 4;
    localparam int unsigned SlotW = 4;
    localparam logic [ModeW-1:0] ModeReset = 4'd4;

    typedef enum logic [ModeW-1:0] {
        t_mode_rgba16 = 4'd0,
        t_mode_r11g11b10 = 4'd1,
        t_mode_rgba8 = 4'd2,
        t_mode_bgra8 = 4'd3,
        t_mode_bc1 = 4'd4,
        t_mode_bc2 = 4'd5,
        t_mode_bc3 = 4'd6,
        t_mode_bc4 = 4'd7,
        t_mode_bc5 = 4'd8
    } t_mode;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
        logic [SlotW-1:0] pixel_slot;
        logic last_of_run;
    } t_pixel;

    // latched job for the pixel sequencer
    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [WordW-1:0] word;
        logic [WordW-1:0] held;
        logic [SlotW-1:0] count_last;
    } t_job;

    // divide a value below 2048 (div3: below 1024) by a small constant through reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'd1366;
        return p[19:12];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] v);
        logic [23:0] p;
        p = 24'(v) * 24'd2341;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] v);
        logic [23:0] p;
        p = 24'(v) * 24'd3277;
        return p[21:14];
    endfunction

    // one entry of the 8-entry endpoint ramp
    function automatic logic [7:0] ramp_entry(input logic [15:0] ep, input logic [2:0] idx);
        logic [7:0] e0;
        logic [7:0] e1;
        logic [2:0] w1;
        logic [2:0] w0;
        logic [10:0] s;
        e0 = ep[7:0];
        e1 = ep[15:8];
        w1 = idx - 3'd1;
        s = '0;
        if (idx == 3'd0) begin
            return e0;
        end
        if (idx == 3'd1) begin
            return e1;
        end
        if (e0 > e1) begin
            w0 = 3'd7 - w1;
            s = 11'(w0) * 11'(e0) + 11'(w1) * 11'(e1);
            return div7(s);
        end
        if (idx == 3'd6) begin
            return 8'h00;
        end
        if (idx == 3'd7) begin
            return 8'hFF;
        end
        w0 = 3'd5 - w1;
        s = 11'(w0) * 11'(e0) + 11'(w1) * 11'(e1);
        return div5(s);
    endfunction

    // one channel of the four-entry colour palette
    function automatic logic [7:0] pal_chan(input logic [7:0] a, input logic [7:0] b,
                                            input logic [1:0] c, input logic four);
        logic [7:0] r;
        unique case (c)
            2'd0: r = a;
            2'd1: r = b;
            2'd2: r = four ? div3({a, 1'b0} + 10'(b)) : 8'((9'(a) + 9'(b)) >> 1);
            default: r = four ? div3(10'(a) + {b, 1'b0}) : 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/tbd_if.sv
// valid/ready channel carrying a payload
interface tbd_if #(parameter type t_data = logic) ();
    logic valid;
    logic ready;
    t_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/tbd_front.sv
// input acceptance, format register and half-block holding
module tbd_front import tbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [ModeW-1:0] i_cfg_data,
    input  logic i_valid,
    input  logic [WordW-1:0] i_word,
    input  logic i_job_ready,
    output logic o_ready,
    output logic o_job_valid,
    output t_job o_job
);

    logic [ModeW-1:0] r_mode;
    logic [WordW-1:0] r_held;
    logic r_pending;
    logic w_fire;
    logic w_two;
    logic w_emit;
    logic w_bad;

    assign o_ready = i_job_ready;
    assign w_fire = i_valid && o_ready;
    assign w_two = (r_mode == t_mode_bc2) || (r_mode == t_mode_bc3) || (r_mode == t_mode_bc5);
    assign w_bad = r_mode > t_mode_bc5;
    assign w_emit = !w_bad && !(w_two && !r_pending);

    assign o_job_valid = i_valid && w_emit;
    always_comb begin
        o_job.mode = r_mode;
        o_job.word = i_word;
        o_job.held = r_held;
        if (r_mode == t_mode_rgba16) begin
            o_job.count_last = 4'd0;
        end else if (r_mode == t_mode_r11g11b10 || r_mode == t_mode_rgba8
                     || r_mode == t_mode_bgra8) begin
            o_job.count_last = 4'd1;
        end else begin
            o_job.count_last = 4'd15;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeReset;
            r_pending <= 1'b0;
            r_held <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
            r_pending <= 1'b0;
        end else if (w_fire && !w_bad) begin
            if (w_two && !r_pending) begin
                r_held <= i_word;
                r_pending <= 1'b1;
            end else begin
                r_pending <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> w_two) else $error("pending outside two-word mode");
    a_first_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_two && !r_pending) |-> !o_job_valid) else $error("first half emitted");
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !r_pending) else $error("config left pending set");
`endif

endmodule

>>> hw/rtl/tbd_pixel.sv
// per-pixel decode of the latched job
module tbd_pixel import tbd_pkg::*; (
    input  t_job i_job,
    input  logic [SlotW-1:0] i_slot,
    output t_pixel o_pix
);

    logic [WordW-1:0] w;
    logic [WordW-1:0] h;
    logic [31:0] v;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [1:0] ci;
    logic four;
    logic [7:0] r0, g0, b0, r1, g1, b1;
    logic [7:0] pr, pg, pb, pa;
    logic [2:0] iw;
    logic [2:0] ih;
    logic [3:0] a4;

    always_comb begin
        w = i_job.word;
        h = i_job.held;
        v = i_slot[0] ? w[63:32] : w[31:0];
        c0 = w[15:0];
        c1 = w[31:16];
        four = c0 > c1;
        ci = 2'(w >> (32 + 2 * 32'(i_slot)));
        iw = 3'(w >> (16 + 3 * 32'(i_slot)));
        ih = 3'(h >> (16 + 3 * 32'(i_slot)));
        a4 = 4'(h >> (4 * 32'(i_slot)));
        r0 = {c0[15:11], 3'b0}; g0 = {c0[10:5], 2'b0}; b0 = {c0[4:0], 3'b0};
        r1 = {c1[15:11], 3'b0}; g1 = {c1[10:5], 2'b0}; b1 = {c1[4:0], 3'b0};
        pr = pal_chan(r0, r1, ci, four);
        pg = pal_chan(g0, g1, ci, four);
        pb = pal_chan(b0, b1, ci, four);
        pa = (!four && ci == 2'd3) ? 8'h00 : 8'hFF;
        o_pix.pixel_slot = i_slot;
        o_pix.last_of_run = i_slot == i_job.count_last;
        unique case (i_job.mode)
            t_mode_rgba16: begin
                o_pix.red = w[15:8]; o_pix.green = w[31:24];
                o_pix.blue = w[47:40]; o_pix.alpha_out = w[63:56];
            end
            t_mode_r11g11b10: begin
                o_pix.red = v[31:24]; o_pix.green = v[20:13];
                o_pix.blue = v[9:2]; o_pix.alpha_out = 8'hFF;
            end
            t_mode_rgba8: begin
                o_pix.red = v[7:0]; o_pix.green = v[15:8];
                o_pix.blue = v[23:16]; o_pix.alpha_out = v[31:24];
            end
            t_mode_bgra8: begin
                o_pix.red = v[23:16]; o_pix.green = v[15:8];
                o_pix.blue = v[7:0]; o_pix.alpha_out = v[31:24];
            end
            t_mode_bc2: begin
                o_pix.red = pr; o_pix.green = pg; o_pix.blue = pb;
                o_pix.alpha_out = {a4, 4'b0};
            end
            t_mode_bc3: begin
                o_pix.red = pr; o_pix.green = pg; o_pix.blue = pb;
                o_pix.alpha_out = ramp_entry(h[15:0], ih);
            end
            t_mode_bc4: begin
                o_pix.red = ramp_entry(w[15:0], iw); o_pix.green = 8'h00;
                o_pix.blue = 8'h00; o_pix.alpha_out = 8'hFF;
            end
            t_mode_bc5: begin
                o_pix.red = ramp_entry(h[15:0], ih); o_pix.green = ramp_entry(w[15:0], iw);
                o_pix.blue = 8'h00; o_pix.alpha_out = 8'hFF;
            end
            default: begin
                o_pix.red = pr; o_pix.green = pg; o_pix.blue = pb; o_pix.alpha_out = pa;
            end
        endcase
    end

endmodule

>>> hw/rtl/tbd_seq.sv
// job register, pixel counter and output register
module tbd_seq import tbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_ready,
    output logic o_valid,
    output t_pixel o_pix,
    input  logic i_ready
);

    logic r_busy;
    t_job r_job;
    logic [SlotW-1:0] r_slot;
    logic r_out_valid;
    t_pixel r_out;
    t_pixel w_pix;
    logic w_load;
    logic w_step;
    logic w_done;

    tbd_pixel u_pixel (.i_job(r_job), .i_slot(r_slot), .o_pix(w_pix));

    assign w_load = !r_out_valid || i_ready;
    assign w_step = r_busy && w_load;
    assign w_done = w_step && (r_slot == r_job.count_last);
    assign o_job_ready = !r_busy || w_done;
    assign o_valid = r_out_valid;
    assign o_pix = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
            r_slot <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= r_busy;
            end
            if (o_job_ready) begin
                r_busy <= i_job_valid;
                r_slot <= '0;
            end else if (w_step) begin
                r_slot <= r_slot + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_ready && i_job_valid) begin
            r_job <= i_job;
        end
        if (w_step) begin
            r_out <= w_pix;
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid && $stable(r_out))
        else $error("output dropped under stall");
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_slot <= r_job.count_last) else $error("slot overrun");
    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_job_ready) |=> $stable(r_job))
        else $error("job changed mid run");
`endif

endmodule

>>> hw/rtl/texture_block_decoder_core.sv
// top level of the texture block decoder
// channel  dir  payload                               transfer
// s_in     in   source_word[63:0]                     valid && ready
// m_out    out  red green blue alpha_out slot last    valid && ready
// cfg      in   format_mode[3:0]                      i_cfg_we
// one pixel per cycle unless m_out stalls: 16 per block word, 2 per packed word, 1 for rgba16
// the pixel counter over the latched job sets this rate; the first half of a block gives none
// next word is taken in the cycle the last pixel of the current one enters the output register
// synchronous active-low reset; output stalls hold the pixel register and the counter
module texture_block_decoder_core import tbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [ModeW-1:0] i_cfg_data,
    tbd_if.sink s_in,
    tbd_if.source m_out
);

    logic w_job_valid;
    logic w_job_ready;
    t_job w_job;

    tbd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(s_in.valid), .i_word(s_in.data), .i_job_ready(w_job_ready),
        .o_ready(s_in.ready), .o_job_valid(w_job_valid), .o_job(w_job)
    );

    tbd_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_job_valid), .i_job(w_job),
        .o_job_ready(w_job_ready), .o_valid(m_out.valid), .o_pix(m_out.data),
        .i_ready(m_out.ready)
    );

endmodule
